// ===== hdl/pipelined_unit_occupancy_defines.svh =====
// Assertion helpers for the occupancy tracker.
`ifndef PIPELINED_UNIT_OCCUPANCY_DEFINES_SVH
`define PIPELINED_UNIT_OCCUPANCY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent in one cycle implies consequent in the next.
`define PUO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("occupancy tracker check failed");

// Antecedent implies consequent in the same cycle.
`define PUO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("occupancy tracker check failed");

`else

`define PUO_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PUO_ASSERT_NOW(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/puo_pkg.sv =====
package puo_pkg;

   localparam int KIND_W = 2;
   localparam int TAG_W  = 8;

   // Event codes; code 3 is unused and changes nothing.
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_ISSUE  = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   typedef logic [TAG_W-1:0] tag_type;

endpackage

// ===== hdl/pipelined_unit_occupancy.sv =====
// Occupancy tracker for a pipelined functional unit with LANES lanes of STAGES
// stages each. Every request transaction carries one event: a tick advances all
// lanes by one stage (last stage falls off, stage 0 empties), an issue writes the
// tag into stage 0 of the lowest-numbered lane with a free stage 0, and a remove
// empties the first stage holding the tag, searched lane by lane and from stage 0
// upward. Each event yields exactly one response transaction: rsp_accepted is set
// only for an issue that found room, and rsp_available tells whether any lane has
// a free stage 0 after the event. Throughput is one transaction per clock while
// the response side keeps taking results. A request is taken into the input
// register; the state update and result register follow in one pass. The tag
// search across all LANES*STAGES entries is the longest path. No clearing pass
// is needed after reset: the block takes requests as soon as reset is released.
`include "pipelined_unit_occupancy_defines.svh"

module pipelined_unit_occupancy #(
   parameter int LANES  = 2,
   parameter int STAGES = 4
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [puo_pkg::KIND_W-1:0] req_kind,
   input  logic [puo_pkg::TAG_W-1:0]  req_tag,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_accepted,
   output logic                       rsp_available
);

   localparam int N = LANES * STAGES;

   // Input register
   logic                       in_valid_ff, in_valid_in;
   logic [puo_pkg::KIND_W-1:0] in_kind_ff,  in_kind_in;
   puo_pkg::tag_type           in_tag_ff,   in_tag_in;

   // Pipeline state, flattened as lane * STAGES + stage
   logic [N-1:0]     stage_valid_ff, stage_valid_in;
   puo_pkg::tag_type stage_tag_ff [N];
   puo_pkg::tag_type stage_tag_in [N];

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_accepted_ff, rsp_accepted_in;
   logic rsp_available_ff, rsp_available_in;

   logic             advance;
   logic [LANES-1:0] free0;
   logic [LANES-1:0] free0_first;
   logic [N-1:0]     match;
   logic [N-1:0]     match_first;
   logic [LANES-1:0] free0_after;

   // The held event moves on when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_tag_in   = in_tag_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_kind;
         in_tag_in   = req_tag;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Lane search: free stage 0s and tag matches, lowest index wins.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         free0[l] = !stage_valid_ff[l*STAGES];
      end
      for (int i = 0; i < N; i++) begin
         match[i] = stage_valid_ff[i] && (stage_tag_ff[i] == in_tag_ff);
      end
   end

   assign free0_first = free0 & (~free0 + LANES'(1));
   assign match_first = match & (~match + N'(1));

   // State update for the held event.
   always_comb begin
      stage_valid_in = stage_valid_ff;
      for (int i = 0; i < N; i++) begin
         stage_tag_in[i] = stage_tag_ff[i];
      end
      rsp_accepted_in = 1'b0;
      if (advance) begin
         case (in_kind_ff)
            puo_pkg::KIND_TICK: begin
               for (int l = 0; l < LANES; l++) begin
                  for (int s = 0; s < STAGES; s++) begin
                     if (s == 0) begin
                        stage_valid_in[l*STAGES] = 1'b0;
                        stage_tag_in[l*STAGES]   = '0;
                     end else begin
                        stage_valid_in[l*STAGES+s] = stage_valid_ff[l*STAGES+s-1];
                        stage_tag_in[l*STAGES+s]   = stage_tag_ff[l*STAGES+s-1];
                     end
                  end
               end
            end
            puo_pkg::KIND_ISSUE: begin
               rsp_accepted_in = |free0;
               for (int l = 0; l < LANES; l++) begin
                  if (free0_first[l]) begin
                     stage_valid_in[l*STAGES] = 1'b1;
                     stage_tag_in[l*STAGES]   = in_tag_ff;
                  end
               end
            end
            puo_pkg::KIND_REMOVE: begin
               for (int i = 0; i < N; i++) begin
                  if (match_first[i]) begin
                     stage_valid_in[i] = 1'b0;
                     stage_tag_in[i]   = '0;
                  end
               end
            end
            default: begin
               // unused code: nothing changes
            end
         endcase
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         free0_after[l] = !stage_valid_in[l*STAGES];
      end
   end

   // Result register: loaded on advance, cleared once taken.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_available_in = rsp_available_ff;
      if (advance) begin
         rsp_valid_in     = 1'b1;
         rsp_available_in = |free0_after;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         stage_valid_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Payload: no reset needed; tags of empty stages are never compared.
   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_tag_ff  <= in_tag_in;
      for (int i = 0; i < N; i++) begin
         stage_tag_ff[i] <= stage_tag_in[i];
      end
      if (advance) begin
         rsp_accepted_ff <= rsp_accepted_in;
      end
      rsp_available_ff <= rsp_available_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_available = rsp_available_ff;

   // A tick always frees every stage 0.
   `PUO_ASSERT_NEXT(a_tick_frees, clock, reset,
      advance && (in_kind_ff == puo_pkg::KIND_TICK), rsp_valid_ff && rsp_available_ff)

   // An issue with every stage 0 occupied is refused.
   `PUO_ASSERT_NEXT(a_full_refuses, clock, reset,
      advance && (in_kind_ff == puo_pkg::KIND_ISSUE) && !(|free0), !rsp_accepted_ff)

   // Only an issue can add occupancy.
   `PUO_ASSERT_NEXT(a_no_growth, clock, reset,
      advance && (in_kind_ff != puo_pkg::KIND_ISSUE),
      $countones(stage_valid_ff) <= $past($countones(stage_valid_ff)))

   // At most one stage is cleared by a remove.
   `PUO_ASSERT_NOW(a_remove_one, clock, reset,
      advance && (in_kind_ff == puo_pkg::KIND_REMOVE), $onehot0(match_first))

endmodule

// ===== verif/tb_pipelined_unit_occupancy.sv =====
`timescale 1ns / 1ps

module tb_pipelined_unit_occupancy;

   localparam int LANES  = 2;
   localparam int STAGES = 4;

   // Code 3 is not part of the package enum; the block must treat it as a no-op.
   localparam logic [puo_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Long receiver hold-off, in cycles, so the pipeline backs up onto req_ready.
   localparam int LONG_HOLD = 50;
   localparam int DRAIN_CYCLES = 10;
   localparam int POOL_SIZE = 6;

   typedef struct {
      logic [puo_pkg::KIND_W-1:0] kind;
      puo_pkg::tag_type           tag;
   } occ_event_type;

   typedef struct {
      logic accepted;
      logic available;
   } occ_status_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [puo_pkg::KIND_W-1:0] req_kind = puo_pkg::KIND_TICK;
   puo_pkg::tag_type           req_tag = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_accepted;
   logic                       rsp_available;

   // Transactions waiting to be offered, and responses the predictor expects.
   occ_event_type  pending_events_q[$];
   occ_status_type expected_status_q[$];

   // Predictor's own copy of the lane/stage occupancy.
   logic             occ_valid[LANES][STAGES];
   puo_pkg::tag_type occ_tag[LANES][STAGES];

   // Idling percentages; changed only on the falling edge.
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        stall_pending = 1'b0;
   int          hold_left = 0;
   int          error_count = 0;

   puo_pkg::tag_type tag_pool[POOL_SIZE];

   pipelined_unit_occupancy #(
      .LANES  (LANES),
      .STAGES (STAGES)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_tag       (req_tag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accepted  (rsp_accepted),
      .rsp_available (rsp_available)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one event to the occupancy copy and returns the status it yields.
   task automatic advance_occupancy(input logic [puo_pkg::KIND_W-1:0] kind,
                                    input puo_pkg::tag_type tag,
                                    output occ_status_type status);
      logic found;
      int   l;
      int   s;
      found = 1'b0;
      status.accepted = 1'b0;
      case (kind)
         puo_pkg::KIND_TICK: begin
            // Every lane moves on one stage; the last stage falls off the end.
            for (l = 0; l < LANES; l++) begin
               for (s = STAGES - 1; s > 0; s--) begin
                  occ_valid[l][s] = occ_valid[l][s-1];
                  occ_tag[l][s]   = occ_tag[l][s-1];
               end
               occ_valid[l][0] = 1'b0;
               occ_tag[l][0]   = '0;
            end
         end
         puo_pkg::KIND_ISSUE: begin
            // Lowest-numbered lane with a free stage 0 takes the tag.
            for (l = 0; l < LANES; l++) begin
               if (!found && !occ_valid[l][0]) begin
                  occ_valid[l][0] = 1'b1;
                  occ_tag[l][0]   = tag;
                  found = 1'b1;
               end
            end
            status.accepted = found;
         end
         puo_pkg::KIND_REMOVE: begin
            // First occupied match, lane by lane then stage upward; empty stages never match.
            for (l = 0; l < LANES; l++) begin
               for (s = 0; s < STAGES; s++) begin
                  if (!found && occ_valid[l][s] && occ_tag[l][s] == tag) begin
                     occ_valid[l][s] = 1'b0;
                     occ_tag[l][s]   = '0;
                     found = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      status.available = 1'b0;
      for (l = 0; l < LANES; l++) begin
         if (!occ_valid[l][0]) begin
            status.available = 1'b1;
         end
      end
   endtask

   task automatic queue_event(input logic [puo_pkg::KIND_W-1:0] kind,
                              input puo_pkg::tag_type tag);
      occ_event_type ev;
      ev.kind = kind;
      ev.tag  = tag;
      pending_events_q.insert(pending_events_q.size(), ev);
   endtask

   // Mostly tags from a small pool so removes hit live entries and duplicates
   // build up; the rest is full range so every tag bit toggles.
   function automatic puo_pkg::tag_type pick_tag();
      if ($urandom_range(99) < 75) begin
         return tag_pool[$urandom_range(POOL_SIZE - 1)];
      end
      return puo_pkg::tag_type'($urandom_range(255));
   endfunction

   task automatic refresh_pool();
      int i;
      for (i = 0; i < POOL_SIZE; i++) begin
         tag_pool[i] = puo_pkg::tag_type'($urandom_range(255));
      end
   endtask

   task automatic queue_random_events(input int count);
      int          i;
      int unsigned roll;
      for (i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            refresh_pool();
         end
         roll = $urandom_range(99);
         if (roll < 30) begin
            queue_event(puo_pkg::KIND_TICK, puo_pkg::tag_type'($urandom_range(255)));
         end else if (roll < 65) begin
            queue_event(puo_pkg::KIND_ISSUE, pick_tag());
         end else if (roll < 95) begin
            queue_event(puo_pkg::KIND_REMOVE, pick_tag());
         end else begin
            queue_event(KIND_UNUSED, pick_tag());
         end
      end
   endtask

   task automatic wait_offered();
      while (pending_events_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: on each accepted transaction the predictor is stepped and
   // its status queued; the next pending transaction is offered only once the
   // current one has gone, so valid and payload hold steady while stalled.
   always @(posedge clock) begin : req_driver
      occ_event_type  ev;
      occ_status_type status;
      if (reset) begin
         req_valid <= 1'b0;
         req_kind  <= puo_pkg::KIND_TICK;
         req_tag   <= '0;
      end else begin
         if (req_valid && req_ready) begin
            advance_occupancy(req_kind, req_tag, status);
            expected_status_q.insert(expected_status_q.size(), status);
         end
         if (!req_valid || req_ready) begin
            if (pending_events_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               ev = pending_events_q.pop_front();
               req_valid <= 1'b1;
               req_kind  <= ev.kind;
               req_tag   <= ev.tag;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side ready: a requested long hold-off is counted down here,
   // otherwise ready is dropped at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (stall_pending) begin
         stall_pending <= 1'b0;
         hold_left     <= LONG_HOLD;
         rsp_ready     <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Response monitor: every accepted response is matched against the oldest
   // expected status, field by field.
   always @(posedge clock) begin : rsp_monitor
      occ_status_type exp_status;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: response with none expected, accepted %0b available %0b",
                     $time, rsp_accepted, rsp_available);
            error_count++;
         end else begin
            exp_status = expected_status_q.pop_front();
            if (rsp_accepted !== exp_status.accepted) begin
               $display("%0t: rsp_accepted mismatch, expected %0b, got %0b",
                        $time, exp_status.accepted, rsp_accepted);
               error_count++;
            end
            if (rsp_available !== exp_status.available) begin
               $display("%0t: rsp_available mismatch, expected %0b, got %0b",
                        $time, exp_status.available, rsp_available);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int l;
      int s;
      for (l = 0; l < LANES; l++) begin
         for (s = 0; s < STAGES; s++) begin
            occ_valid[l][s] = 1'b0;
            occ_tag[l][s]   = '0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty unit, tag extremes, full stage 0, unused code,
      // absent tags, duplicates, falling off the end, cleared tag bits.
      queue_event(puo_pkg::KIND_REMOVE, 8'h00);  // empty stages must not match tag 0
      queue_event(puo_pkg::KIND_TICK,   8'hFF);
      queue_event(puo_pkg::KIND_ISSUE,  8'h00);
      queue_event(puo_pkg::KIND_ISSUE,  8'hFF);
      queue_event(puo_pkg::KIND_ISSUE,  8'h5A);  // no lane free, refused
      queue_event(KIND_UNUSED,          8'hA5);
      queue_event(puo_pkg::KIND_REMOVE, 8'h33);  // absent
      queue_event(puo_pkg::KIND_TICK,   8'h00);
      queue_event(puo_pkg::KIND_ISSUE,  8'hAA);
      queue_event(puo_pkg::KIND_TICK,   8'h00);
      queue_event(puo_pkg::KIND_ISSUE,  8'hAA);  // duplicate in lane 0, stages 0 and 1
      queue_event(puo_pkg::KIND_REMOVE, 8'hAA);  // stage 0 copy goes first
      queue_event(puo_pkg::KIND_REMOVE, 8'hAA);
      queue_event(puo_pkg::KIND_REMOVE, 8'hAA);  // none left
      queue_event(puo_pkg::KIND_ISSUE,  8'h0F);
      // drain everything off the end
      repeat (STAGES + 1) queue_event(puo_pkg::KIND_TICK, 8'h55);
      queue_event(puo_pkg::KIND_REMOVE, 8'h00);
      queue_event(puo_pkg::KIND_ISSUE,  8'hF0);
      queue_event(puo_pkg::KIND_ISSUE,  8'h3C);
      queue_event(puo_pkg::KIND_TICK,   8'h00);
      queue_event(puo_pkg::KIND_REMOVE, 8'h00);  // stage 0 emptied by tick, tag bits 0
      queue_event(KIND_UNUSED,          8'hFF);
      wait_offered();

      // Back to back, no idling either side.
      queue_random_events(400);
      wait_offered();

      // Receiver holds off for a long stretch while the sender keeps offering.
      stall_pending = 1'b1;
      queue_random_events(60);
      wait_offered();

      sender_idle_pct = 83;
      queue_random_events(450);
      wait_offered();

      sender_idle_pct = 0;
      rsp_stall_pct   = 83;
      queue_random_events(450);
      wait_offered();

      sender_idle_pct = 19;
      rsp_stall_pct   = 19;
      queue_random_events(450);
      wait_offered();

      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      queue_random_events(150);
      wait_offered();

      // Drain: everything offered; wait for the last responses, then a margin
      // of DRAIN_CYCLES for anything stray.
      while (req_valid || expected_status_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
